// File: hw/rtl/cbcp_pkg.sv
// Shared constants and the coefficient table of the complex block correlator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cbcp_pkg;

    // Default sample width and accumulator growth over the sample width.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_GROWTH      = 7;

    // Bank geometry: four banks of 2, 4, 8 and 16 taps inside a 16-sample frame.
    localparam int NUM_BANKS = 4;
    localparam int BANK_BITS = 2;
    localparam int POS_BITS  = 4;

    // Coefficient magnitude in quarters, signed.
    localparam int COEF_BITS = 4;

    // Width of the power field.
    localparam int POWER_BITS = 44;

    // Bank that closes a group of results.
    localparam logic [BANK_BITS-1:0] LAST_BANK = BANK_BITS'(NUM_BANKS - 1);

    typedef logic signed [COEF_BITS-1:0] t_coef;

    // Tap weights; each tap is weight * (1 - j) in quarters.
    localparam t_coef COEF_B0 [2] = '{4'sd2, -4'sd2};
    localparam t_coef COEF_B1 [4] = '{4'sd1, 4'sd2, -4'sd1, -4'sd2};
    localparam t_coef COEF_B2 [8] = '{4'sd2, 4'sd4, 4'sd2, 4'sd0,
                                      -4'sd2, -4'sd4, -4'sd2, 4'sd0};
    localparam t_coef COEF_B3 [16] = '{4'sd1, 4'sd2, 4'sd3, 4'sd4,
                                       4'sd3, 4'sd2, 4'sd1, 4'sd0,
                                       -4'sd1, -4'sd2, -4'sd3, -4'sd4,
                                       -4'sd3, -4'sd2, -4'sd1, 4'sd0};

    // Weight of a bank at the given frame position; each bank uses the low
    // bits of the position as its tap index.
    function automatic t_coef coef(input logic [BANK_BITS-1:0] bank,
                                   input logic [POS_BITS-1:0] pos);
        t_coef c;
        unique case (bank)
            2'd0: c = COEF_B0[pos[0]];
            2'd1: c = COEF_B1[pos[1:0]];
            2'd2: c = COEF_B2[pos[2:0]];
            2'd3: c = COEF_B3[pos];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/cbcp_accum.sv
// Per-bank complex accumulators and the frame position counter.
// Uses cbcp_pkg for the bank geometry and the coefficient table.
`timescale 1ns / 1ps

module cbcp_accum #(
    parameter int SAMPLE_BITS = cbcp_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = SAMPLE_BITS + cbcp_pkg::ACC_GROWTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    input  logic                       i_end_of_stream,
    output logic                       o_load,
    output logic signed [ACC_BITS-1:0] o_acc_real [cbcp_pkg::NUM_BANKS],
    output logic signed [ACC_BITS-1:0] o_acc_imag [cbcp_pkg::NUM_BANKS]
);

    localparam int TERM_BITS = SAMPLE_BITS + 1 + cbcp_pkg::COEF_BITS;

    logic signed [ACC_BITS-1:0] r_acc_real [cbcp_pkg::NUM_BANKS];
    logic signed [ACC_BITS-1:0] r_acc_imag [cbcp_pkg::NUM_BANKS];
    logic signed [ACC_BITS-1:0] n_acc_real [cbcp_pkg::NUM_BANKS];
    logic signed [ACC_BITS-1:0] n_acc_imag [cbcp_pkg::NUM_BANKS];
    logic [cbcp_pkg::POS_BITS-1:0] r_pos;
    logic [cbcp_pkg::POS_BITS-1:0] n_pos;

    logic signed [SAMPLE_BITS:0] w_sum;
    logic signed [SAMPLE_BITS:0] w_dif;

    // The tap a*(1 - j) turns the product into a*(re + im) + j*a*(im - re).
    assign w_sum = (SAMPLE_BITS + 1)'(i_sample_real) + (SAMPLE_BITS + 1)'(i_sample_imag);
    assign w_dif = (SAMPLE_BITS + 1)'(i_sample_imag) - (SAMPLE_BITS + 1)'(i_sample_real);

    // Next accumulator values; a bank restarts on the first tap of its block.
    always_comb begin
        logic signed [TERM_BITS-1:0] term_re;
        logic signed [TERM_BITS-1:0] term_im;
        logic [cbcp_pkg::POS_BITS-1:0] mask;
        logic first;
        cbcp_pkg::t_coef c;
        for (int b = 0; b < cbcp_pkg::NUM_BANKS; b++) begin
            mask    = cbcp_pkg::POS_BITS'((2 << b) - 1);
            first   = (r_pos & mask) == '0;
            c       = cbcp_pkg::coef(cbcp_pkg::BANK_BITS'(b), r_pos);
            term_re = c * w_sum;
            term_im = c * w_dif;
            n_acc_real[b] = (first ? '0 : r_acc_real[b]) + ACC_BITS'(term_re);
            n_acc_imag[b] = (first ? '0 : r_acc_imag[b]) + ACC_BITS'(term_im);
        end
    end

    // The position returns to the frame start after the end of a stream.
    assign n_pos = i_end_of_stream ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int b = 0; b < cbcp_pkg::NUM_BANKS; b++) begin
                r_acc_real[b] <= '0;
                r_acc_imag[b] <= '0;
            end
        end else if (i_valid) begin
            r_pos <= n_pos;
            for (int b = 0; b < cbcp_pkg::NUM_BANKS; b++) begin
                r_acc_real[b] <= n_acc_real[b];
                r_acc_imag[b] <= n_acc_imag[b];
            end
        end
    end

    // The sums that include the closing sample go straight to the snapshot.
    assign o_load     = i_valid && i_end_of_stream;
    assign o_acc_real = n_acc_real;
    assign o_acc_imag = n_acc_imag;

endmodule

// File: hw/rtl/cbcp_power.sv
// Block-sum snapshot and the squaring readout, one bank a cycle unless stalled.
// Uses cbcp_pkg for the bank count and the power field width.
`timescale 1ns / 1ps

module cbcp_power #(
    parameter int ACC_BITS = cbcp_pkg::SAMPLE_BITS_DEF + cbcp_pkg::ACC_GROWTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic signed [ACC_BITS-1:0]          i_acc_real [cbcp_pkg::NUM_BANKS],
    input  logic signed [ACC_BITS-1:0]          i_acc_imag [cbcp_pkg::NUM_BANKS],
    output logic                                o_busy,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [cbcp_pkg::BANK_BITS-1:0]      o_filter_index,
    output logic [cbcp_pkg::POWER_BITS-1:0]     o_block_power,
    output logic                                o_last_result
);

    localparam int PROD_BITS = 2 * ACC_BITS;
    localparam int EXT_BITS  = (PROD_BITS > cbcp_pkg::POWER_BITS) ? PROD_BITS
                                                                  : cbcp_pkg::POWER_BITS;

    logic signed [ACC_BITS-1:0] r_snap_re [cbcp_pkg::NUM_BANKS];
    logic signed [ACC_BITS-1:0] r_snap_im [cbcp_pkg::NUM_BANKS];
    logic                              r_busy;
    logic [cbcp_pkg::BANK_BITS-1:0]    r_idx;
    logic                              r_a_valid;
    logic [cbcp_pkg::BANK_BITS-1:0]    r_a_idx;
    logic [cbcp_pkg::POWER_BITS-1:0]   r_sq_re;
    logic [cbcp_pkg::POWER_BITS-1:0]   r_sq_im;
    logic                              r_out_valid;
    logic [cbcp_pkg::BANK_BITS-1:0]    r_out_idx;
    logic [cbcp_pkg::POWER_BITS-1:0]   r_out_power;

    logic                              w_b_adv;
    logic                              w_a_free;
    logic                              w_issue;
    logic signed [PROD_BITS-1:0]       w_prod_re;
    logic signed [PROD_BITS-1:0]       w_prod_im;
    logic [EXT_BITS-1:0]               w_ext_re;
    logic [EXT_BITS-1:0]               w_ext_im;

    // Pipeline flow: each stage moves when the one after it has room.
    assign w_b_adv  = !r_out_valid || !i_stall;
    assign w_a_free = !r_a_valid || w_b_adv;
    assign w_issue  = r_busy && w_a_free;

    // Squares of the selected bank; a square is never negative, so it
    // widens without change before the field is cut out.
    assign w_prod_re = r_snap_re[r_idx] * r_snap_re[r_idx];
    assign w_prod_im = r_snap_im[r_idx] * r_snap_im[r_idx];
    assign w_ext_re  = EXT_BITS'(w_prod_re);
    assign w_ext_im  = EXT_BITS'(w_prod_im);

    // Snapshot of the four block sums; a new one is taken only when idle.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap_re <= i_acc_real;
            r_snap_im <= i_acc_imag;
        end
    end

    // Readout sequencer over the four banks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == cbcp_pkg::LAST_BANK) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Square stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_a_idx <= r_idx;
            r_sq_re <= w_ext_re[cbcp_pkg::POWER_BITS-1:0];
            r_sq_im <= w_ext_im[cbcp_pkg::POWER_BITS-1:0];
        end
    end

    // Result register: the power field wraps at its own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_b_adv) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv && r_a_valid) begin
            r_out_idx   <= r_a_idx;
            r_out_power <= r_sq_re + r_sq_im;
        end
    end

    assign o_busy         = r_busy;
    assign o_valid        = r_out_valid;
    assign o_filter_index = r_out_idx;
    assign o_block_power  = r_out_power;
    assign o_last_result  = r_out_idx == cbcp_pkg::LAST_BANK;

endmodule

// File: hw/rtl/complex_block_correlator_power_top.sv
// Top level of the complex block correlator with block-power readout.
// Depends on cbcp_pkg, cbcp_accum and cbcp_power.
`timescale 1ns / 1ps

// The block takes one complex sample per clock cycle while the input is not
// stalled and runs it through four correlator banks of 2, 4, 8 and 16 taps in
// parallel; a sample that is not flagged end_of_stream causes no result. A
// flagged sample freezes the four bank sums in a snapshot, and one squaring
// stage then delivers the four powers one after another, bank 0 first, each
// through the square stage and the result register. Samples keep flowing while
// the powers drain; only a further flagged sample that reaches the accumulators
// while the snapshot has not been fully read out waits, and the input stalls
// until the last bank has left the snapshot. The input register doubles as the
// skid stage.
module complex_block_correlator_power_top #(
    parameter int SAMPLE_BITS = cbcp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_imag,
    input  logic                                i_end_of_stream,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cbcp_pkg::BANK_BITS-1:0]      o_filter_index,
    output logic [cbcp_pkg::POWER_BITS-1:0]     o_block_power,
    output logic                                o_last_result
);

    localparam int ACC_BITS = SAMPLE_BITS + cbcp_pkg::ACC_GROWTH;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_real;
    logic signed [SAMPLE_BITS-1:0] r_in_imag;
    logic                          r_in_eos;

    logic                          w_hold;
    logic                          w_accept;
    logic                          w_consume;
    logic                          w_busy;
    logic                          w_load;
    logic signed [ACC_BITS-1:0]    w_acc_real [cbcp_pkg::NUM_BANKS];
    logic signed [ACC_BITS-1:0]    w_acc_imag [cbcp_pkg::NUM_BANKS];

    // A closing sample waits in the input register until the snapshot is free.
    assign w_hold     = r_in_valid && r_in_eos && w_busy;
    assign o_in_stall = w_hold;
    assign w_accept   = i_in_valid && !w_hold;
    assign w_consume  = r_in_valid && !w_hold;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!w_hold) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_real <= i_sample_real;
            r_in_imag <= i_sample_imag;
            r_in_eos  <= i_end_of_stream;
        end
    end

    cbcp_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_consume),
        .i_sample_real   (r_in_real),
        .i_sample_imag   (r_in_imag),
        .i_end_of_stream (r_in_eos),
        .o_load          (w_load),
        .o_acc_real      (w_acc_real),
        .o_acc_imag      (w_acc_imag)
    );

    cbcp_power #(
        .ACC_BITS (ACC_BITS)
    ) u_power (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_acc_real     (w_acc_real),
        .i_acc_imag     (w_acc_imag),
        .o_busy         (w_busy),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_filter_index (o_filter_index),
        .o_block_power  (o_block_power),
        .o_last_result  (o_last_result)
    );

endmodule

// File: hw/rtl/cbcp_checker.sv
// Port-level checks on the result stream of the correlator top level.
// Depends on cbcp_pkg; attached to complex_block_correlator_power_top by bind.
`timescale 1ns / 1ps

module cbcp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [cbcp_pkg::BANK_BITS-1:0]  o_filter_index,
    input logic [cbcp_pkg::POWER_BITS-1:0] o_block_power,
    input logic                            o_last_result
);

    logic [cbcp_pkg::BANK_BITS-1:0] r_exp_index;

    // Bank number expected on the next result; groups always run 0 to 3.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_index <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_exp_index <= o_filter_index + 1'b1;
        end
    end

    // Results come in complete groups in bank order.
    a_bank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_filter_index == r_exp_index)
        else $error("result out of bank order");

    // The closing flag marks exactly the last bank of a group.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last_result == (o_filter_index == cbcp_pkg::LAST_BANK))
        else $error("last_result does not match the bank number");

    // A stalled result stays offered and unchanged.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_block_power)
            && $stable(o_filter_index))
        else $error("stalled result changed");

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind complex_block_correlator_power_top cbcp_checker u_cbcp_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for complex_block_correlator_power_top.
// Sample streams in, bank powers out; depends on cbcp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

    localparam int SW              = cbcp_pkg::SAMPLE_BITS_DEF;
    localparam int ACC_W           = SW + cbcp_pkg::ACC_GROWTH;
    localparam int CLK_HALF        = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PRESSURE_ITEMS  = 30;
    localparam int RANDOM_ITEMS    = 120;
    localparam int REPORT_MAX      = 10;

    // Tap weights in quarters for each bank; every tap is weight * (1 - j).
    localparam int TAP_WEIGHT [cbcp_pkg::NUM_BANKS][16] = '{
        '{2, -2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 2, -1, -2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{2, 4, 2, 0, -2, -4, -2, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 2, 3, 4, 3, 2, 1, 0, -1, -2, -3, -4, -3, -2, -1, 0}
    };

    typedef logic [cbcp_pkg::NUM_BANKS-1:0][cbcp_pkg::POWER_BITS-1:0] t_bank_powers;

    typedef struct {
        logic [cbcp_pkg::BANK_BITS-1:0]  bank;
        logic [cbcp_pkg::POWER_BITS-1:0] power;
        logic                            last;
    } t_bank_power;

    typedef struct {
        int           re;
        int           im;
        bit           eos;
        bit           typed;
        t_bank_powers pw;
    } t_sample_row;

    // Block ports.
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic signed [SW-1:0]            i_sample_real;
    logic signed [SW-1:0]            i_sample_imag;
    logic                            i_end_of_stream;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [cbcp_pkg::BANK_BITS-1:0]  o_filter_index;
    logic [cbcp_pkg::POWER_BITS-1:0] o_block_power;
    logic                            o_last_result;

    // Correlator state as the testbench tracks it.
    logic signed [ACC_W-1:0]         acc_re [cbcp_pkg::NUM_BANKS];
    logic signed [ACC_W-1:0]         acc_im [cbcp_pkg::NUM_BANKS];
    logic [cbcp_pkg::POS_BITS-1:0]   frame_pos;

    t_bank_power  powers_due [$];
    t_sample_row  dir_rows [$];
    t_bank_powers no_typed;

    int  cycle_count;
    int  mismatch_count;
    int  results_checked;
    int  samples_sent;
    int  streams_ended;
    int  burst_left;
    bit  steady;
    bit  hold_req;
    bit  hold_done;

    complex_block_correlator_power_top #(
        .SAMPLE_BITS(SW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_real  (i_sample_real),
        .i_sample_imag  (i_sample_imag),
        .i_end_of_stream(i_end_of_stream),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_filter_index (o_filter_index),
        .o_block_power  (o_block_power),
        .o_last_result  (o_last_result)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Cycle counter; a run that hangs ends here.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d powers outstanding",
                     cycle_count, powers_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Advance the correlator by one sample. On a flagged sample the four bank powers
    // are returned and the frame position starts over.
    task automatic correlate_sample(input int yr, input int yi, input bit eos,
                                    output t_bank_powers pw);
        int     s;
        int     d;
        int     tap;
        int     b;
        longint re;
        longint im;
        longint p;
        s = yr + yi;
        d = yi - yr;
        pw = '0;
        for (b = 0; b < cbcp_pkg::NUM_BANKS; b++) begin
            tap = int'(frame_pos) & ((2 << b) - 1);
            if (tap == 0) begin
                acc_re[b] = '0;
                acc_im[b] = '0;
            end
            acc_re[b] = ACC_W'(acc_re[b] + TAP_WEIGHT[b][tap] * s);
            acc_im[b] = ACC_W'(acc_im[b] + TAP_WEIGHT[b][tap] * d);
            re = acc_re[b];
            im = acc_im[b];
            p = re * re + im * im;
            pw[b] = p[cbcp_pkg::POWER_BITS-1:0];
        end
        frame_pos = eos ? '0 : frame_pos + 1'b1;
    endtask

    // Offer one sample request and hold it until the block takes it, then record
    // the powers it must produce and pace the sender with bursts and gaps.
    task automatic send_sample(input int yr, input int yi, input bit eos,
                               input bit use_typed, input t_bank_powers typed_pw);
        t_bank_powers pw;
        t_bank_power  due;
        int           b;
        i_in_valid      <= 1'b1;
        i_sample_real   <= SW'(yr);
        i_sample_imag   <= SW'(yi);
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_in_stall);
        correlate_sample(yr, yi, eos, pw);
        samples_sent++;
        if (eos) begin
            streams_ended++;
            for (b = 0; b < cbcp_pkg::NUM_BANKS; b++) begin
                due.bank  = cbcp_pkg::BANK_BITS'(b);
                due.power = use_typed ? typed_pw[b] : pw[b];
                due.last  = (b == cbcp_pkg::NUM_BANKS - 1);
                powers_due.push_back(due);
            end
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
            if (!steady) begin
                // Idle with junk on the payload; the block must ignore it.
                i_in_valid      <= 1'b0;
                i_sample_real   <= SW'($urandom);
                i_sample_imag   <= SW'($urandom);
                i_end_of_stream <= 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    // Sample part biased toward the extremes of the Q1.15 range.
    function automatic int rand_part();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return ($urandom_range(0, 1) != 0) ? 0 : -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // One stream of random samples with the end flag on its last sample.
    task automatic send_stream(input int len);
        int n;
        for (n = 1; n <= len; n++) begin
            send_sample(rand_part(), rand_part(), n == len, 1'b0, no_typed);
        end
    endtask

    task automatic add_row(input int re, input int im, input bit eos, input bit typed,
                           input longint p0, input longint p1,
                           input longint p2, input longint p3);
        t_sample_row row;
        row.re    = re;
        row.im    = im;
        row.eos   = eos;
        row.typed = typed;
        row.pw[0] = p0[cbcp_pkg::POWER_BITS-1:0];
        row.pw[1] = p1[cbcp_pkg::POWER_BITS-1:0];
        row.pw[2] = p2[cbcp_pkg::POWER_BITS-1:0];
        row.pw[3] = p3[cbcp_pkg::POWER_BITS-1:0];
        dir_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                     field, results_checked, want, got);
        end
    endtask

    // Compare every accepted result with the oldest expected bank power.
    always @(posedge i_clk) begin
        t_bank_power due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (powers_due.size() == 0) begin
                report_mismatch("unexpected result, bank", -1, o_filter_index);
            end else begin
                due = powers_due.pop_front();
                if (o_filter_index !== due.bank) begin
                    report_mismatch("filter_index", due.bank, o_filter_index);
                end
                if (o_block_power !== due.power) begin
                    report_mismatch("block_power", due.power, o_block_power);
                end
                if (o_last_result !== due.last) begin
                    report_mismatch("last_result", due.last, o_last_result);
                end
            end
            results_checked++;
        end
    end

    // Result side: stall patterns that change from segment to segment, and one long
    // hold-off when the stimulus asks for it.
    initial begin
        int mode;
        int seg_left;
        int held;
        seg_left = 0;
        mode = 0;
        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (seg_left == 0) begin
                mode = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 120);
            end
            seg_left--;
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= (seg_left % 4 == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Reset, directed table, pressure burst, random streams, drain and verdict.
    initial begin
        int          r;
        int          len;
        int          base;
        t_sample_row row;
        no_typed        = '0;
        frame_pos       = '0;
        mismatch_count  = 0;
        results_checked = 0;
        samples_sent    = 0;
        streams_ended   = 0;
        steady          = 1'b0;
        burst_left      = 4;
        for (r = 0; r < cbcp_pkg::NUM_BANKS; r++) begin
            acc_re[r] = '0;
            acc_im[r] = '0;
        end
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_sample_real   <= '0;
        i_sample_imag   <= '0;
        i_end_of_stream <= 1'b0;

        // Single-sample streams whose powers follow from the first tap of each bank.
        add_row(0, 0, 1, 1, 0, 0, 0, 0);
        add_row(1, 0, 1, 1, 8, 2, 8, 2);
        add_row(-32768, -32768, 1, 1, 64'd17179869184, 64'd4294967296,
                64'd17179869184, 64'd4294967296);
        add_row(32767, -32768, 1, 1, 64'd17179344904, 64'd4294836226,
                64'd17179344904, 64'd4294836226);
        add_row(-32768, 32767, 1, 1, 64'd17179344904, 64'd4294836226,
                64'd17179344904, 64'd4294836226);
        add_row(32767, 32767, 1, 1, 64'd17178820624, 64'd4294705156,
                64'd17178820624, 64'd4294705156);
        // Eleven samples: every bank ends on a partial block.
        add_row(32767, 32767, 0, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, 0, 0, 0, 0, 0, 0);
        add_row(32767, -32768, 0, 0, 0, 0, 0, 0);
        add_row(-32768, 32767, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0);
        add_row(-1, -1, 0, 0, 0, 0, 0, 0);
        add_row(1, 1, 0, 0, 0, 0, 0, 0);
        add_row(12345, -23456, 0, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 0, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 0, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, 1, 0, 0, 0, 0, 0);
        // Flagged samples back to back while the previous powers still drain.
        add_row(-32768, -32768, 1, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 1, 0, 0, 0, 0, 0);
        add_row(100, -200, 1, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_sample(row.re, row.im, row.eos, row.typed, row.pw);
        end

        // Short streams at full rate while the result side holds off, so the
        // snapshot stays full and the input has to stall.
        hold_req = 1'b1;
        steady = 1'b1;
        base = samples_sent;
        while (samples_sent - base < PRESSURE_ITEMS) begin
            send_stream($urandom_range(1, 3));
        end
        steady = 1'b0;

        // Random streams, mostly of moderate length, some short, some spanning frames.
        base = samples_sent;
        while (samples_sent - base < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                len = $urandom_range(1, 3);
            end else if (r < 8) begin
                len = $urandom_range(4, 20);
            end else begin
                len = $urandom_range(17, 40);
            end
            send_stream(len);
        end
        i_in_valid <= 1'b0;

        while (powers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples in %0d streams, checked %0d bank powers, %0d mismatches.",
                 samples_sent, streams_ended, results_checked, mismatch_count);
        $display("Covered extremes, partial blocks, back-to-back stream ends %s%0d cycles.",
                 "and a hold-off of ", HOLD_OFF_CYCLES);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
